// ===== src/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types and constants for the streaming pattern matcher.
// ----------------------------------------------------------------------------
package kmp_pkg;

    localparam int MAX_PATTERN_DEF = 64;

    typedef enum logic {
        CMD_PATTERN = 1'b0,
        CMD_TEXT    = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OVERFLOW   = 2'd1,
        ST_NO_PATTERN = 2'd2
    } t_status;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic step;   // text byte: advance partial-match bits
        logic clear;  // drop all partial matches
        logic build;  // pattern complete: latch tail marks
    } t_cell_ctl;

endpackage

// ===== src/kmp_cell.sv =====
// ----------------------------------------------------------------------------
// kmp_cell
// One pattern position: holds its byte, a tail mark and the partial-match bit
// saying the pattern prefix ending at this position matches the text so far.
// ----------------------------------------------------------------------------
module kmp_cell
    import kmp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_wr,
    input  logic      i_tail,
    input  logic [7:0] i_symbol,
    input  logic      i_prev_match,
    output logic      o_match,
    output logic      o_hit
);

    logic [7:0] r_sym;
    logic       r_tail;
    logic       r_match;
    logic       n_match;
    logic       w_step_val;

    assign w_step_val = i_prev_match && (i_symbol == r_sym);
    assign o_hit      = i_ctl.step && w_step_val && r_tail;
    assign o_match    = r_match;

    always_comb begin
        n_match = r_match;
        if (i_ctl.clear) begin
            n_match = 1'b0;
        end else if (i_ctl.step) begin
            n_match = w_step_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_sym <= i_symbol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
            r_tail  <= 1'b0;
        end else begin
            r_match <= n_match;
            if (i_ctl.build) begin
                r_tail <= i_tail;
            end
        end
    end

endmodule

// ===== src/kmp_stream_matcher.sv =====
// ----------------------------------------------------------------------------
// kmp_stream_matcher
// Single-pattern streaming byte matcher built from a row of match cells.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with i_cmd/i_symbol/i_last; the item is taken when busy is
//   low. busy never rises, so one item may be issued every cycle.
//   Pattern bytes (CMD_PATTERN) fill cells 0..MAX_PATTERN-1 in order; extra
//   bytes are dropped and reported as overflow. The pattern byte flagged
//   last arms the matcher. Text bytes (CMD_TEXT) then step every cell at
//   once: each cell's match bit follows its left neighbor's bit from the
//   previous byte, so all overlapping occurrences are reported.
//   Each item gives one result in the cycle after acceptance, marked by o_valid
//   for a single cycle: o_match_end, sticky o_found, o_status. The receiver
//   cannot stall; results must be taken as they appear.
//   Throughput 1 item per cycle; the critical path is the
//   byte compare in each cell plus the OR over all cell hits.
//   Reset clears the pattern length, flags and all match bits; no pattern
//   is loaded afterwards and text items answer with status no-pattern.
// ----------------------------------------------------------------------------
module kmp_stream_matcher
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_cmd,
    input  logic [7:0] i_symbol,
    input  logic       i_last,
    output logic       o_valid,
    output logic       o_match_end,
    output logic       o_found,
    output logic [1:0] o_status
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_PATTERN);

    logic          w_accept;
    logic          w_is_text;
    logic          w_text_go;
    t_cell_ctl     w_ctl;

    logic [LW-1:0] r_len, n_len;
    logic          r_ovf, n_ovf;
    logic          r_ready, n_ready;
    logic          r_found, n_found;

    logic [LW-1:0] w_base_len;
    logic          w_base_ovf;
    logic          w_room;
    logic [LW-1:0] w_last_idx;

    logic [MAX_PATTERN-1:0] w_match;
    logic [MAX_PATTERN-1:0] w_hit;
    logic                   w_any_hit;

    logic    r_valid;
    logic    r_match_end, n_match_end;
    logic    r_found_out, n_found_out;
    t_status r_status, n_status;

    assign busy      = 1'b0;
    assign w_accept  = start && !busy;
    assign w_is_text = (t_cmd'(i_cmd) == CMD_TEXT);
    assign w_text_go = w_accept && w_is_text && r_ready;

    // a new pattern discards the armed one
    assign w_base_len = r_ready ? '0 : r_len;
    assign w_base_ovf = r_ready ? 1'b0 : r_ovf;
    assign w_room     = (w_base_len < LEN_MAX);
    assign w_last_idx = w_room ? w_base_len : (w_base_len - LW'(1));

    always_comb begin
        w_ctl.step  = w_text_go;
        w_ctl.clear = w_accept && (!w_is_text || (r_ready && i_last));
        w_ctl.build = w_accept && !w_is_text && i_last;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++) begin : g_cell
            logic w_prev;
            logic w_wr;
            logic w_tail;
            if (gi == 0) begin : g_head
                assign w_prev = 1'b1;
            end else begin : g_body
                assign w_prev = w_match[gi-1];
            end
            assign w_wr   = w_accept && !w_is_text && (w_base_len == LW'(gi));
            assign w_tail = (w_last_idx == LW'(gi));
            kmp_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_wr         (w_wr),
                .i_tail       (w_tail),
                .i_symbol     (i_symbol),
                .i_prev_match (w_prev),
                .o_match      (w_match[gi]),
                .o_hit        (w_hit[gi])
            );
        end
    endgenerate

    assign w_any_hit = |w_hit;

    always_comb begin
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_ready     = r_ready;
        n_found     = r_found;
        n_match_end = 1'b0;
        n_found_out = 1'b0;
        n_status    = ST_OK;
        if (w_accept) begin
            if (!w_is_text) begin
                n_len   = w_room ? (w_base_len + LW'(1)) : w_base_len;
                n_ovf   = w_base_ovf || !w_room;
                n_ready = i_last;
                n_found = 1'b0;
                n_status = n_ovf ? ST_OVERFLOW : ST_OK;
            end else if (r_ready) begin
                n_match_end = w_any_hit;
                n_found_out = r_found || w_any_hit;
                n_found     = i_last ? 1'b0 : n_found_out;
                n_status    = r_ovf ? ST_OVERFLOW : ST_OK;
            end else begin
                n_status = ST_NO_PATTERN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_ovf   <= 1'b0;
            r_ready <= 1'b0;
            r_found <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_len   <= n_len;
            r_ovf   <= n_ovf;
            r_ready <= n_ready;
            r_found <= n_found;
            r_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_match_end <= n_match_end;
        r_found_out <= n_found_out;
        r_status    <= n_status;
    end

    assign o_valid     = r_valid;
    assign o_match_end = r_match_end;
    assign o_found     = r_found_out;
    assign o_status    = r_status;

`ifndef SYNTH
    a_hit_sets_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_match_end |-> o_found)
        else $error("match reported without found");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("accepted item gave no result");

    a_no_hit_unarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_match_end |-> o_status != ST_NO_PATTERN)
        else $error("match reported without a pattern");

    a_armed_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_len != '0) && (r_len <= LEN_MAX))
        else $error("armed with bad pattern length");
`endif

endmodule
